// ===== rtl/wdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdt_pkg
// Shared types and constants for the watchlist device tracker.
// ----------------------------------------------------------------------------
package wdt_pkg;

    localparam int DEVICE_SLOTS_DEF = 64;

    // APB: 64-bit data (filter registers are 50 bits), 8-byte register stride
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    localparam int ADDR_W = 48;
    localparam int TIME_W = 32;
    localparam int WIN_W  = 20;
    localparam int FILT_W = 50;
    localparam int NUM_FILT = 4;

    localparam int FILT_FULL_BIT  = 48;
    localparam int FILT_VALID_BIT = 49;
    localparam int PREFIX_LSB     = 24;

    // register indexes (paddr[5:3])
    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_FILT_A     = 3'd1;
    localparam logic [2:0] REG_FILT_B     = 3'd2;
    localparam logic [2:0] REG_FILT_C     = 3'd3;
    localparam logic [2:0] REG_FILT_D     = 3'd4;
    localparam logic [2:0] REG_SHORT_WIN  = 3'd5;
    localparam logic [2:0] REG_LONG_WIN   = 3'd6;
    localparam logic [2:0] REG_LONG_COOL  = 3'd7;

    localparam logic [WIN_W-1:0] SHORT_WIN_RST = 20'd3000;
    localparam logic [WIN_W-1:0] LONG_WIN_RST  = 20'd30000;
    localparam logic [WIN_W-1:0] LONG_COOL_RST = 20'd10000;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_NEW   = 2'd1,
        EV_SHORT = 2'd2,
        EV_LONG  = 2'd3
    } t_event;

    typedef struct packed {
        logic                             enable;
        logic [NUM_FILT-1:0][FILT_W-1:0]  filt;
        logic [WIN_W-1:0]                 short_win;
        logic [WIN_W-1:0]                 long_win;
        logic [WIN_W-1:0]                 long_cool;
    } t_wdt_cfg;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch transaction, rewind scan
        logic filt;       // latch matching filter slot
        logic clear;      // empty the device table
        logic scan;       // issue next table read
        logic chk;        // register cooldown test and gap
        logic upd;        // update known device, report
        logic app;        // append new device, report
        logic emit_none;  // report an empty event
    } t_wdt_cmd;

    // datapath -> controller
    typedef struct packed {
        logic action;
        logic enable;
        logic fmatch;
        logic hit;
        logic exhausted;
    } t_wdt_sts;

endpackage

// ===== rtl/watchlist_device_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// watchlist_device_tracker
// Filters advertisements against four address slots and tracks matching
// devices in a table, reporting new devices and re-sightings after gaps.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                       Payload
// -------   ---------  ------------------------------  ---------------------
// command   in         start & !busy                   i_action, i_mac,
//                                                      i_rssi, i_now_ms
// result    out        o_done (one-cycle strobe)       o_event_res,
//                                                      o_event_mac,
//                                                      o_event_rssi,
//                                                      o_filter_index,
//                                                      o_table_full
// config    in/out     APB, write on psel&penable&     pwdata -> reg paddr[5:3]
//                      pwrite (pready tied high)
//
// Sequencing: one transaction at a time. Clear, disabled or unmatched
// transactions report from the filter state. A matched advertisement scans
// the table entries up to the fill count (at most 64 by default) until a
// hit, then checks and updates that entry, or appends a new one if none
// matches: the table memory is read one entry per cycle, with the compare
// on the registered read data in the cycle after the read.
// Reset: synchronous, active low; clears the sequencer, fill count and
// registers to defaults. Table contents need no clearing, only entries below
// the fill count are ever read.
// Stalls: the receiver cannot stall; busy drops in the cycle o_done rises,
// so the next transaction may be accepted while the result is shown.
// ----------------------------------------------------------------------------
module watchlist_device_tracker import wdt_pkg::*; #(
    parameter int DEVICE_SLOTS = DEVICE_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  logic              i_action,
    input  logic [ADDR_W-1:0] i_mac,
    input  logic signed [7:0] i_rssi,
    input  logic [TIME_W-1:0] i_now_ms,
    // result channel
    output logic              o_done,
    output logic [1:0]        o_event_res,
    output logic [ADDR_W-1:0] o_event_mac,
    output logic signed [7:0] o_event_rssi,
    output logic [1:0]        o_filter_index,
    output logic              o_table_full,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_wdt_cfg cfg;
    t_wdt_cmd cmd;
    t_wdt_sts sts;

    // register file; the user must write it only while no transaction is in flight (not enforced here)
    wdt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: accepts the transaction, walks the table, picks the outcome
    wdt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // filters, device table memory, time arithmetic and result register
    wdt_dpath #(
        .DEVICE_SLOTS (DEVICE_SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_mac          (i_mac),
        .i_rssi         (i_rssi),
        .i_now_ms       (i_now_ms),
        .o_done         (o_done),
        .o_event_res    (o_event_res),
        .o_event_mac    (o_event_mac),
        .o_event_rssi   (o_event_rssi),
        .o_filter_index (o_filter_index),
        .o_table_full   (o_table_full)
    );

endmodule

// ===== rtl/wdt_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdt_cfg
// APB register file: enable, four filter slots, window and cooldown times.
// ----------------------------------------------------------------------------
module wdt_cfg import wdt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_wdt_cfg          o_cfg
);

    logic                             r_enable;
    logic [NUM_FILT-1:0][FILT_W-1:0]  r_filt;
    logic [WIN_W-1:0]                 r_short_win;
    logic [WIN_W-1:0]                 r_long_win;
    logic [WIN_W-1:0]                 r_long_cool;
    logic                             wr_en;
    logic [2:0]                       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_AW-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_filt      <= '0;
            r_short_win <= SHORT_WIN_RST;
            r_long_win  <= LONG_WIN_RST;
            r_long_cool <= LONG_COOL_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ENABLE:    r_enable    <= pwdata[0];
                REG_FILT_A:    r_filt[0]   <= pwdata[FILT_W-1:0];
                REG_FILT_B:    r_filt[1]   <= pwdata[FILT_W-1:0];
                REG_FILT_C:    r_filt[2]   <= pwdata[FILT_W-1:0];
                REG_FILT_D:    r_filt[3]   <= pwdata[FILT_W-1:0];
                REG_SHORT_WIN: r_short_win <= pwdata[WIN_W-1:0];
                REG_LONG_WIN:  r_long_win  <= pwdata[WIN_W-1:0];
                REG_LONG_COOL: r_long_cool <= pwdata[WIN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_ENABLE:    prdata = {{(APB_DW-1){1'b0}}, r_enable};
            REG_FILT_A:    prdata = {{(APB_DW-FILT_W){1'b0}}, r_filt[0]};
            REG_FILT_B:    prdata = {{(APB_DW-FILT_W){1'b0}}, r_filt[1]};
            REG_FILT_C:    prdata = {{(APB_DW-FILT_W){1'b0}}, r_filt[2]};
            REG_FILT_D:    prdata = {{(APB_DW-FILT_W){1'b0}}, r_filt[3]};
            REG_SHORT_WIN: prdata = {{(APB_DW-WIN_W){1'b0}}, r_short_win};
            REG_LONG_WIN:  prdata = {{(APB_DW-WIN_W){1'b0}}, r_long_win};
            REG_LONG_COOL: prdata = {{(APB_DW-WIN_W){1'b0}}, r_long_cool};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.enable    = r_enable;
    assign o_cfg.filt      = r_filt;
    assign o_cfg.short_win = r_short_win;
    assign o_cfg.long_win  = r_long_win;
    assign o_cfg.long_cool = r_long_cool;

endmodule

// ===== rtl/wdt_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdt_dpath
// Filter match, device table memory with pipelined scan, update and append.
// ----------------------------------------------------------------------------
module wdt_dpath import wdt_pkg::*; #(
    parameter int DEVICE_SLOTS = DEVICE_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_wdt_cfg          i_cfg,
    input  t_wdt_cmd          i_cmd,
    output t_wdt_sts          o_sts,
    input  logic              i_action,
    input  logic [ADDR_W-1:0] i_mac,
    input  logic signed [7:0] i_rssi,
    input  logic [TIME_W-1:0] i_now_ms,
    output logic              o_done,
    output logic [1:0]        o_event_res,
    output logic [ADDR_W-1:0] o_event_mac,
    output logic signed [7:0] o_event_rssi,
    output logic [1:0]        o_filter_index,
    output logic              o_table_full
);

    localparam int IW = $clog2(DEVICE_SLOTS);
    localparam int CW = $clog2(DEVICE_SLOTS + 1);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] last;
        logic [TIME_W-1:0] cool_until;
        logic              cooling;
    } t_dev;

    t_dev r_mem [DEVICE_SLOTS];

    logic              r_action;
    logic [ADDR_W-1:0] r_mac;
    logic signed [7:0] r_rssi;
    logic [TIME_W-1:0] r_now;
    logic [1:0]        r_fidx;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_ptr;
    t_dev              r_rd;
    logic [IW-1:0]     r_cmp_idx;
    logic              r_cmp_vld;
    logic              r_block;
    logic [TIME_W-1:0] r_since;

    logic              r_done;
    t_event            r_ev_res;
    logic [ADDR_W-1:0] r_ev_mac;
    logic signed [7:0] r_ev_rssi;
    logic [1:0]        r_ev_fidx;
    logic              r_ev_full;

    logic [NUM_FILT-1:0] fm;
    logic [1:0]          fidx;
    logic                room;
    logic                rd_ok;
    logic                gap_long;
    logic                gap_short;
    logic [TIME_W-1:0]   cool_add;
    logic [TIME_W-1:0]   cool_next;
    logic                mem_we;
    logic [IW-1:0]       mem_wa;
    t_dev                mem_wd;
    t_event              n_ev_res;
    logic                n_ev_full;

    // filter match, first slot wins
    always_comb begin
        fidx = '0;
        for (int i = 0; i < NUM_FILT; i++) begin
            fm[i] = i_cfg.filt[i][FILT_VALID_BIT] &&
                    (i_cfg.filt[i][FILT_FULL_BIT]
                        ? (i_cfg.filt[i][ADDR_W-1:0] == r_mac)
                        : (i_cfg.filt[i][ADDR_W-1:PREFIX_LSB] ==
                           r_mac[ADDR_W-1:PREFIX_LSB]));
        end
        for (int i = NUM_FILT - 1; i >= 0; i--) begin
            if (fm[i]) fidx = 2'(i);
        end
    end

    assign room  = r_count < CW'(DEVICE_SLOTS);
    assign rd_ok = r_ptr < r_count;

    // gap classification from registered elapsed time
    assign gap_long  = r_since >= {{(TIME_W-WIN_W){1'b0}}, i_cfg.long_win};
    assign gap_short = r_since >= {{(TIME_W-WIN_W){1'b0}}, i_cfg.short_win};
    assign cool_add  = gap_long ? {{(TIME_W-WIN_W){1'b0}}, i_cfg.long_cool}
                                : {{(TIME_W-WIN_W){1'b0}}, i_cfg.short_win};
    assign cool_next = r_now + cool_add;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cmp_idx;
        mem_wd = r_rd;
        if (i_cmd.upd && !r_block) begin
            mem_we          = 1'b1;
            mem_wd.last     = r_now;
            mem_wd.cooling  = gap_long | gap_short;
            if (gap_long | gap_short) mem_wd.cool_until = cool_next;
        end else if (i_cmd.app && room) begin
            mem_we             = 1'b1;
            mem_wa             = r_count[IW-1:0];
            mem_wd.addr        = r_mac;
            mem_wd.last        = r_now;
            mem_wd.cool_until  = r_now + {{(TIME_W-WIN_W){1'b0}}, i_cfg.short_win};
            mem_wd.cooling     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (i_cmd.scan && rd_ok) r_rd <= r_mem[r_ptr[IW-1:0]];
    end

    // transaction and scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ptr     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= rd_ok;
                if (rd_ok) begin
                    r_ptr     <= r_ptr + 1'b1;
                    r_cmp_idx <= r_ptr[IW-1:0];
                end
            end
            if (i_cmd.clear) r_count <= '0;
            else if (i_cmd.app && room) r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_mac    <= i_mac;
            r_rssi   <= i_rssi;
            r_now    <= i_now_ms;
        end
        if (i_cmd.filt) r_fidx <= fidx;
        if (i_cmd.chk) begin
            r_block <= r_rd.cooling && (r_now < r_rd.cool_until);
            r_since <= r_now - r_rd.last;
        end
    end

    // result register
    always_comb begin
        n_ev_res  = EV_NONE;
        n_ev_full = 1'b0;
        if (i_cmd.upd && !r_block) begin
            if (gap_long)       n_ev_res = EV_LONG;
            else if (gap_short) n_ev_res = EV_SHORT;
        end else if (i_cmd.app) begin
            n_ev_res  = EV_NEW;
            n_ev_full = !room;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit_none | i_cmd.upd | i_cmd.app;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_none | i_cmd.upd | i_cmd.app) begin
            r_ev_res  <= n_ev_res;
            r_ev_full <= n_ev_full;
            if (n_ev_res == EV_NONE) begin
                r_ev_mac  <= '0;
                r_ev_rssi <= '0;
                r_ev_fidx <= '0;
            end else begin
                r_ev_mac  <= r_mac;
                r_ev_rssi <= r_rssi;
                r_ev_fidx <= r_fidx;
            end
        end
    end

    assign o_sts.action    = r_action;
    assign o_sts.enable    = i_cfg.enable;
    assign o_sts.fmatch    = |fm;
    assign o_sts.hit       = r_cmp_vld && (r_rd.addr == r_mac);
    assign o_sts.exhausted = !r_cmp_vld && !rd_ok;

    assign o_done         = r_done;
    assign o_event_res    = r_ev_res;
    assign o_event_mac    = r_ev_mac;
    assign o_event_rssi   = r_ev_rssi;
    assign o_filter_index = r_ev_fidx;
    assign o_table_full   = r_ev_full;

endmodule

// ===== rtl/wdt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdt_ctrl
// Sequencer: filter check or table clear, table scan, known-device update or append.
// ----------------------------------------------------------------------------
module wdt_ctrl import wdt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_wdt_sts i_sts,
    output t_wdt_cmd o_cmd,
    output logic     o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILT,
        S_SCAN,
        S_CHK,
        S_UPD,
        S_APP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FILT;
                end
            end
            S_FILT: begin
                if (i_sts.action) begin
                    o_cmd.clear     = 1'b1;
                    o_cmd.emit_none = 1'b1;
                    n_state         = S_IDLE;
                end else if (!i_sts.enable || !i_sts.fmatch) begin
                    o_cmd.emit_none = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.filt = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    n_state = S_CHK;
                end else if (i_sts.exhausted) begin
                    n_state = S_APP;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_IDLE;
            end
            S_APP: begin
                o_cmd.app = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule
